FILE: sv/qmn_pkg.sv
// Shared types and constants for the normalized quaternion product unit.
package qmn_pkg;

  localparam int CompBits  = 32;
  localparam int FracBits  = CompBits - 2;
  localparam int ProdBits  = 2 * CompBits;
  localparam int PSumBits  = 2 * CompBits + 2;
  localparam int PMagBits  = 2 * CompBits + 1;
  localparam int LoBits    = CompBits;
  localparam int HiBits    = PMagBits - LoBits;
  localparam int SqBits    = 4 * CompBits + 1;
  localparam int SumBits   = 4 * CompBits + 3;
  localparam int RemBits   = 6 * CompBits + 4;
  localparam int QuoBits   = FracBits + 1;
  localparam int NumDigits = QuoBits;

  // b operand index and subtract flag for the four terms of each component
  localparam logic [1:0] TermB [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic TermNeg [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  typedef struct packed {
    logic signed [CompBits-1:0] a_w;
    logic signed [CompBits-1:0] a_x;
    logic signed [CompBits-1:0] a_y;
    logic signed [CompBits-1:0] a_z;
    logic signed [CompBits-1:0] b_w;
    logic signed [CompBits-1:0] b_x;
    logic signed [CompBits-1:0] b_y;
    logic signed [CompBits-1:0] b_z;
  } qmn_in_t;

  typedef struct packed {
    logic signed [CompBits-1:0] r_w;
    logic signed [CompBits-1:0] r_x;
    logic signed [CompBits-1:0] r_y;
    logic signed [CompBits-1:0] r_z;
    logic                       zero_norm;
  } qmn_out_t;

  // state carried through the rounding digit stages
  typedef struct packed {
    logic                          vld;
    logic                          zero;
    logic [SumBits-1:0]            s;
    logic [3:0][RemBits-1:0]       rem;
    logic [3:0][RemBits-1:0]       acc;
    logic [3:0][QuoBits-1:0]       quo;
    logic [3:0]                    neg;
  } qmn_stage_t;

endpackage

FILE: sv/qmn_product.sv
// Hamilton product: sixteen signed products, then four exact signed sums.
module qmn_product import qmn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  qmn_in_t                    word_i,
  output logic                       valid_o,
  output logic [3:0][PSumBits-1:0]   p_o
);

  logic signed [CompBits-1:0] a_c [4];
  logic signed [CompBits-1:0] b_c [4];
  logic signed [ProdBits-1:0] prod_q [4][4];
  logic signed [PSumBits-1:0] psum_d [4];
  logic [1:0]                 vld_q;

  assign a_c = '{word_i.a_w, word_i.a_x, word_i.a_y, word_i.a_z};
  assign b_c = '{word_i.b_w, word_i.b_x, word_i.b_y, word_i.b_z};

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[i][k] <= ProdBits'($signed(a_c[k]) * $signed(b_c[TermB[i][k]]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      psum_d[i] = '0;
      for (int k = 0; k < 4; k++) begin
        if (TermNeg[i][k]) begin
          psum_d[i] = psum_d[i] - PSumBits'(prod_q[i][k]);
        end else begin
          psum_d[i] = psum_d[i] + PSumBits'(prod_q[i][k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      p_o[i] <= psum_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  assign valid_o = vld_q[1];

endmodule

FILE: sv/qmn_square_sum.sv
// Magnitudes, split squares, sum of squares and initial rounding residues.
module qmn_square_sum import qmn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [3:0][PSumBits-1:0]   p_i,
  output qmn_stage_t                 stage_o
);

  logic [PMagBits-1:0]        mag_q [4];
  logic [3:0]                 neg_q, neg2_q, neg3_q, neg4_q;
  logic [2*HiBits-1:0]        hh_q [4];
  logic [HiBits+LoBits-1:0]   hl_q [4];
  logic [2*LoBits-1:0]        ll_q [4];
  logic [SqBits-1:0]          sq_q [4];
  logic [SqBits-1:0]          sq2_q [4];
  logic [SumBits-1:0]         sum_d, sum_q;
  logic [4:0]                 vld_q;
  qmn_stage_t                 stage_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      // magnitude and sign
      neg_q[i] <= p_i[i][PSumBits-1];
      mag_q[i] <= p_i[i][PSumBits-1] ? PMagBits'(-$signed(p_i[i])) : PMagBits'(p_i[i]);
      // partial products of the split magnitude
      hh_q[i]  <= (2*HiBits)'(mag_q[i][PMagBits-1:LoBits]) * mag_q[i][PMagBits-1:LoBits];
      hl_q[i]  <= (HiBits+LoBits)'(mag_q[i][PMagBits-1:LoBits]) * mag_q[i][LoBits-1:0];
      ll_q[i]  <= (2*LoBits)'(mag_q[i][LoBits-1:0]) * mag_q[i][LoBits-1:0];
      // assembled square
      sq_q[i]  <= (SqBits'(hh_q[i]) << (2*LoBits)) + (SqBits'(hl_q[i]) << (LoBits+1))
                  + SqBits'(ll_q[i]);
      sq2_q[i] <= sq_q[i];
    end
    neg2_q <= neg_q;
    neg3_q <= neg2_q;
    neg4_q <= neg3_q;
    sum_q  <= sum_d;
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 4; i++) begin
      sum_d = sum_d + SumBits'(sq_q[i]);
    end
  end

  // residue = p^2 * 2^(2F+2) - S, running term starts at -S (odd factor -1)
  always_ff @(posedge clk_i) begin
    stage_q.vld  <= vld_q[3];
    stage_q.zero <= (sum_q == '0);
    stage_q.s    <= sum_q;
    stage_q.neg  <= neg4_q;
    for (int i = 0; i < 4; i++) begin
      stage_q.rem[i] <= (RemBits'(sq2_q[i]) << (2*FracBits+2)) - RemBits'(sum_q);
      stage_q.acc[i] <= RemBits'(0) - RemBits'(sum_q);
      stage_q.quo[i] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // valid comes from the reset chain
  always_comb begin
    stage_o     = stage_q;
    stage_o.vld = vld_q[4];
  end

endmodule

FILE: sv/qmn_digit_stage.sv
// One quotient bit of the rounded normalization for all four lanes.
module qmn_digit_stage import qmn_pkg::*; #(
  parameter int Bit = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qmn_stage_t stage_i,
  output qmn_stage_t stage_o
);

  logic [RemBits-1:0] s_ext;
  logic [RemBits-1:0] dlt_c  [4];
  logic [RemBits-1:0] cand_c [4];
  logic [3:0]         take_c;
  logic               vld_q;
  qmn_stage_t         stage_d, stage_q;

  assign s_ext = RemBits'(stage_i.s);

  // trial: (t + 2^(Bit+1))^2 S = t^2 S + 2^(Bit+2) tS + 2^(2Bit+2) S
  always_comb begin
    stage_d = stage_i;
    for (int l = 0; l < 4; l++) begin
      dlt_c[l]  = (stage_i.acc[l] << (Bit+2)) + (s_ext << (2*Bit+2));
      cand_c[l] = stage_i.rem[l] - dlt_c[l];
      take_c[l] = ~cand_c[l][RemBits-1];
      if (take_c[l]) begin
        stage_d.rem[l]      = cand_c[l];
        stage_d.acc[l]      = stage_i.acc[l] + (s_ext << (Bit+1));
        stage_d.quo[l][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= stage_i.vld;
    end
  end

  // valid comes from the reset flop
  always_comb begin
    stage_o     = stage_q;
    stage_o.vld = vld_q;
  end

endmodule

FILE: sv/quaternion_multiply_normalize_unit.sv
// Top level of the normalized quaternion product unit.
//
//  channel  | handshake          | payload            | direction
//  ---------+--------------------+--------------------+----------
//  command  | start_i / busy_o   | word_i   qmn_in_t  | in
//  result   | valid_o (strobe)   | result_o qmn_out_t | out
//
// One word is taken every cycle; busy_o is always low since the pipe never stalls.
// The pipe holds the products and sums, then magnitudes, squares and the sum of squares,
// then 31 rounding digit stages (one quotient bit each), then the output register.
// Rate is set by the digit stages, each one wide subtract and compare per lane.
// Reset clears only the valid bits; data registers carry no reset.
// Results appear for one cycle on valid_o and must be taken then.
module quaternion_multiply_normalize_unit import qmn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  qmn_in_t  word_i,
  output logic     valid_o,
  output qmn_out_t result_o
);

  logic                      p_vld;
  logic [3:0][PSumBits-1:0]  p_sum;
  qmn_stage_t                chain [NumDigits+1];
  logic [CompBits-1:0]       r_c [4];
  qmn_out_t                  result_d, result_q;
  logic                      valid_q;

  assign busy_o = 1'b0;

  qmn_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .word_i  (word_i),
    .valid_o (p_vld),
    .p_o     (p_sum)
  );

  qmn_square_sum u_square_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_vld),
    .p_i     (p_sum),
    .stage_o (chain[0])
  );

  // quotient bits, most significant first
  for (genvar g = 0; g < NumDigits; g++) begin : g_digit
    qmn_digit_stage #(
      .Bit (NumDigits - 1 - g)
    ) u_digit (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  // apply sign; zero norm forces zeros and raises the flag
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (chain[NumDigits].zero) begin
        r_c[l] = '0;
      end else if (chain[NumDigits].neg[l]) begin
        r_c[l] = CompBits'(0) - CompBits'(chain[NumDigits].quo[l]);
      end else begin
        r_c[l] = CompBits'(chain[NumDigits].quo[l]);
      end
    end
    result_d.r_w       = r_c[0];
    result_d.r_x       = r_c[1];
    result_d.r_y       = r_c[2];
    result_d.r_z       = r_c[3];
    result_d.zero_norm = chain[NumDigits].zero;
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= chain[NumDigits].vld;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
